// ===== rtl/pdcm_pkg.sv =====
// ----------------------------------------------------------------------------
// pdcm_pkg
// Shared widths, constants and types of the PWM duty capture meter.
// ----------------------------------------------------------------------------
package pdcm_pkg;

    localparam int CHANNELS   = 4;
    localparam int CH_BITS    = $clog2(CHANNELS);
    localparam int STAMP_BITS = 16;
    localparam int SPAN_BITS  = STAMP_BITS + 1;
    localparam int DUTY_BITS  = 10;
    localparam int NUM_BITS   = SPAN_BITS + DUTY_BITS;
    localparam int STEP_BITS  = $clog2(DUTY_BITS);
    localparam int MDATA_BITS = ((DUTY_BITS + 2 * SPAN_BITS + 7) / 8) * 8;
    localparam int MPAD_BITS  = MDATA_BITS - DUTY_BITS - 2 * SPAN_BITS;

    localparam logic [DUTY_BITS-1:0] PERMILLE = DUTY_BITS'(1000);
    localparam logic [SPAN_BITS-1:0] WRAP_MAX = SPAN_BITS'(1) << STAMP_BITS;
    localparam logic [SPAN_BITS-1:0] WRAP_MIN = SPAN_BITS'(2);
    localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(DUTY_BITS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_OUT
    } top_state_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_LOAD,
        DIV_RUN
    } div_state_t;

    // capture event handed to the channel store
    typedef struct packed {
        logic                  stb;
        logic [CH_BITS-1:0]    ch;
        logic [STAMP_BITS-1:0] ts;
    } chan_evt_t;

    // outcome of one event, registered in the channel store
    typedef struct packed {
        logic                 valid;
        logic                 emit;
        logic [CH_BITS-1:0]   ch;
        logic [SPAN_BITS-1:0] period;
        logic [SPAN_BITS-1:0] high;
    } chan_res_t;

endpackage

// ===== rtl/pwm_duty_capture_meter.sv =====
// An accepted falling-edge beat reaches its result beat through evaluate and
// multiply, load, the quotient bits of the divider, and the handoff.
// Beats are taken one at a time: no beat is taken until the last has left the
// evaluate, divide and output states; the bit-serial divider sets the pace, and
// the next beat is taken while a result still waits in the output register.
// Reset: all channels expect a rising edge, no period known, wrap = 65536.
// ----------------------------------------------------------------------------
// pwm_duty_capture_meter
// Four-channel PWM capture meter reporting period, high time and duty.
// ----------------------------------------------------------------------------
module pwm_duty_capture_meter (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [pdcm_pkg::SPAN_BITS-1:0]    cfg_wdata,  // counter_wrap
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [pdcm_pkg::STAMP_BITS-1:0]   s_tdata,    // timestamp
    input  logic [pdcm_pkg::CH_BITS-1:0]      s_tuser,    // channel
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // duty_permille, period_ticks, high_ticks, zero pad
    output logic [pdcm_pkg::MDATA_BITS-1:0]   m_tdata,
    output logic [pdcm_pkg::CH_BITS-1:0]      m_tuser     // out_channel
);
    import pdcm_pkg::*;

    top_state_t           state_reg, state_next;
    logic [SPAN_BITS-1:0] wrap_reg, wrap_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [MDATA_BITS-1:0] m_tdata_reg, m_tdata_next;
    logic [CH_BITS-1:0]   m_tuser_reg, m_tuser_next;

    chan_evt_t            evt;
    chan_res_t            res;
    logic                 div_start;
    logic                 div_done;
    logic [DUTY_BITS-1:0] duty;
    logic                 accept;

    assign accept  = s_tvalid && s_tready;
    assign evt.stb = accept;
    assign evt.ch  = s_tuser;
    assign evt.ts  = s_tdata;

    pdcm_chan_store u_chan (
        .clk   (clk),
        .rst_n (rst_n),
        .wrap  (wrap_reg),
        .evt   (evt),
        .res   (res)
    );

    pdcm_divider u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .high   (res.high),
        .period (res.period),
        .done   (div_done),
        .duty   (duty)
    );

    // clamp the wrap into its legal range
    always_comb
    begin
        wrap_next = wrap_reg;
        if (cfg_we)
        begin
            if (cfg_wdata < WRAP_MIN)
            begin
                wrap_next = WRAP_MIN;
            end
            else if (cfg_wdata > WRAP_MAX)
            begin
                wrap_next = WRAP_MAX;
            end
            else
            begin
                wrap_next = cfg_wdata;
            end
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        s_tready      = 1'b0;
        div_start     = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (res.emit)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                // hold until the output register is free
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{MPAD_BITS{1'b0}}, res.high, res.period, duty};
                    m_tuser_next  = res.ch;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            wrap_reg     <= WRAP_MAX;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            wrap_reg     <= wrap_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_one_beat_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_tready)
        else $error("second beat accepted during evaluation");

    a_done_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside divide phase");

    a_duty_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> m_tdata_reg[DUTY_BITS-1:0] <= PERMILLE)
        else $error("duty above 1000 per mille");

endmodule

// ===== rtl/pdcm_chan_store.sv =====
// ----------------------------------------------------------------------------
// pdcm_chan_store
// Per-channel edge state; forms period and high time of each capture event.
// ----------------------------------------------------------------------------
module pdcm_chan_store (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [pdcm_pkg::SPAN_BITS-1:0] wrap,
    input  pdcm_pkg::chan_evt_t         evt,
    output pdcm_pkg::chan_res_t         res
);
    import pdcm_pkg::*;

    logic                  expect_falling_reg [CHANNELS];
    logic                  rise_seen_reg      [CHANNELS];
    logic [STAMP_BITS-1:0] last_rise_reg      [CHANNELS];
    logic [SPAN_BITS-1:0]  period_reg         [CHANNELS];
    chan_res_t             res_reg;
    chan_res_t             res_next;

    logic                  falling;
    logic [STAMP_BITS-1:0] last_ts;
    logic [SPAN_BITS-1:0]  diff_direct;
    logic [SPAN_BITS-1:0]  diff_wrap;
    logic [SPAN_BITS-1:0]  elapsed;

    assign falling     = expect_falling_reg[evt.ch];
    assign last_ts     = last_rise_reg[evt.ch];
    assign diff_direct = {1'b0, evt.ts} - {1'b0, last_ts};
    assign diff_wrap   = {1'b0, evt.ts} + wrap - {1'b0, last_ts};

    // equal stamps: full wrap for a period, zero for a high time
    always_comb
    begin
        if (falling)
        begin
            elapsed = (evt.ts >= last_ts) ? diff_direct : diff_wrap;
        end
        else
        begin
            elapsed = (evt.ts > last_ts) ? diff_direct : diff_wrap;
        end
    end

    always_comb
    begin
        res_next        = res_reg;
        res_next.valid  = evt.stb;
        if (evt.stb)
        begin
            res_next.ch     = evt.ch;
            res_next.period = period_reg[evt.ch];
            res_next.high   = elapsed;
            res_next.emit   = falling && rise_seen_reg[evt.ch] &&
                              (period_reg[evt.ch] != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                expect_falling_reg[i] <= 1'b0;
                rise_seen_reg[i]      <= 1'b0;
                last_rise_reg[i]      <= '0;
                period_reg[i]         <= '0;
            end
            res_reg <= '0;
        end
        else
        begin
            res_reg <= res_next;
            if (evt.stb)
            begin
                expect_falling_reg[evt.ch] <= !falling;
                if (!falling)
                begin
                    period_reg[evt.ch]    <= rise_seen_reg[evt.ch] ? elapsed : '0;
                    last_rise_reg[evt.ch] <= evt.ts;
                    rise_seen_reg[evt.ch] <= 1'b1;
                end
            end
        end
    end

    assign res = res_reg;

    a_emit_has_period: assert property (@(posedge clk) disable iff (!rst_n)
        res_reg.valid && res_reg.emit |-> res_reg.period != '0)
        else $error("duty emitted with unknown period");

endmodule

// ===== rtl/pdcm_divider.sv =====
// ----------------------------------------------------------------------------
// pdcm_divider
// Bit-serial restoring divider: floor(high*1000/period), saturated at 1000.
// ----------------------------------------------------------------------------
module pdcm_divider (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [pdcm_pkg::SPAN_BITS-1:0] high,
    input  logic [pdcm_pkg::SPAN_BITS-1:0] period,
    output logic                          done,
    output logic [pdcm_pkg::DUTY_BITS-1:0] duty
);
    import pdcm_pkg::*;

    div_state_t             state_reg, state_next;
    logic [STEP_BITS-1:0]   step_reg, step_next;
    logic [NUM_BITS-1:0]    num_reg, num_next;
    logic [SPAN_BITS-1:0]   den_reg, den_next;
    logic [SPAN_BITS-1:0]   rem_reg, rem_next;
    logic [DUTY_BITS-1:0]   sh_reg, sh_next;
    logic                   sat_reg, sat_next;
    logic                   done_reg, done_next;

    logic [SPAN_BITS:0]     trial;
    logic                   fits;

    // shift in the next numerator bit; the freed low bit takes the quotient bit
    assign trial = {rem_reg, sh_reg[DUTY_BITS-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        num_next   = num_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        sh_next    = sh_reg;
        sat_next   = sat_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            DIV_IDLE:
            begin
                if (start)
                begin
                    num_next   = NUM_BITS'(high) * NUM_BITS'(PERMILLE);
                    den_next   = period;
                    sat_next   = high >= period;
                    state_next = DIV_LOAD;
                end
            end
            DIV_LOAD:
            begin
                // high below period keeps the quotient under 1024
                rem_next   = num_reg[NUM_BITS-1:DUTY_BITS];
                sh_next    = num_reg[DUTY_BITS-1:0];
                step_next  = '0;
                state_next = DIV_RUN;
            end
            DIV_RUN:
            begin
                rem_next  = fits ? SPAN_BITS'(trial - {1'b0, den_reg})
                                 : trial[SPAN_BITS-1:0];
                sh_next   = {sh_reg[DUTY_BITS-2:0], fits};
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    done_next  = 1'b1;
                    state_next = DIV_IDLE;
                end
            end
            default:
            begin
                state_next = DIV_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DIV_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        sat_reg <= sat_next;
    end

    assign done = done_reg;
    assign duty = sat_reg ? PERMILLE : sh_reg;

    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == DIV_RUN && !sat_reg |-> rem_reg < den_reg)
        else $error("partial remainder not below divisor");

endmodule
